/* hw/rtl/lspid_pkg.sv */
// ----------------------------------------------------------------------------
// Panel-ID responder package
// Transaction types, register offsets and panel-ID command tables that the
// responder uses.
// ----------------------------------------------------------------------------
package lspid_pkg;

    // Request transaction: one bus register access.
    typedef struct packed {
        logic        req_type;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
    } req_t;

    // Response transaction: read value and busy flag after the access.
    typedef struct packed {
        logic [31:0] read_data;
        logic        busy_flag;
    } rsp_t;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Register byte offsets.
    localparam logic [11:0] OFS_CTRL0  = 12'h000;
    localparam logic [11:0] OFS_CTRL1  = 12'h004;
    localparam logic [11:0] OFS_DATA   = 12'h008;
    localparam logic [11:0] OFS_STATUS = 12'h00C;
    localparam logic [11:0] OFS_DATA2  = 12'h018;

    // Frame and status constants.
    localparam int          FRAME_W       = 9;
    localparam logic [31:0] STATUS_BASE   = 32'h0000_0002;
    localparam logic [31:0] STATUS_CNT_MASK = 32'h0000_003F;
    localparam int          STATUS_CNT_LSB  = 4;

    // Panel-ID commands.
    localparam logic [7:0] CMD_READ_ID  = 8'h04;
    localparam logic [7:0] CMD_ID1      = 8'hDA;
    localparam logic [7:0] CMD_ID2      = 8'hDB;
    localparam logic [7:0] CMD_ID3      = 8'hDC;
    localparam logic [7:0] CMD_ID_LAST  = 8'hDF;

    // ID byte values returned by the single-byte ID commands.
    localparam logic [7:0] ID1_BYTE = 8'h06;
    localparam logic [7:0] ID2_BYTE = 8'h85;
    localparam logic [7:0] ID3_BYTE = 8'h4A;

    // Response words for the full ID read.
    localparam logic [8:0] RID_WORD0 = 9'h000;
    localparam logic [8:0] RID_WORD1 = 9'h006;
    localparam logic [8:0] RID_WORD2 = 9'h10A;
    localparam logic [8:0] RID_WORD3 = 9'h128;

    // True for a byte that names a panel-ID command.
    function automatic logic is_id_byte(input logic [7:0] b);
        is_id_byte = (b == CMD_READ_ID) || ((b >= CMD_ID1) && (b <= CMD_ID_LAST));
    endfunction

    // Number of response words that a panel-ID command queues.
    function automatic logic [2:0] id_resp_len(input logic [7:0] cmd);
        if (cmd == CMD_READ_ID) begin
            id_resp_len = 3'd4;
        end else if ((cmd >= CMD_ID1) && (cmd <= CMD_ID3)) begin
            id_resp_len = 3'd1;
        end else begin
            id_resp_len = 3'd0;
        end
    endfunction

    // Response word at a queue slot for a panel-ID command.
    function automatic logic [8:0] id_resp_word(input logic [7:0] cmd, input logic [1:0] idx);
        logic [7:0] id_byte;
        id_byte = ID3_BYTE;
        if (cmd == CMD_ID1) begin
            id_byte = ID1_BYTE;
        end else if (cmd == CMD_ID2) begin
            id_byte = ID2_BYTE;
        end
        if (cmd == CMD_READ_ID) begin
            case (idx)
                2'd0:    id_resp_word = RID_WORD0;
                2'd1:    id_resp_word = RID_WORD1;
                2'd2:    id_resp_word = RID_WORD2;
                default: id_resp_word = RID_WORD3;
            endcase
        end else begin
            id_resp_word = {id_byte, 1'b0};
        end
    endfunction

endpackage

/* hw/rtl/lcd_spi_panel_id_responder_top.sv */
// ----------------------------------------------------------------------------
// Panel-ID responder top level
// Register front end of an SPI display controller with a receive FIFO and a
// canned panel-ID response queue.
// ----------------------------------------------------------------------------
// The block takes one register access per clock cycle while req_stall is low
// and registers its response transaction. All state updates for an
// access (control registers, response queue, receive FIFO pointers and busy)
// finish in the cycle of acceptance, so back-to-back accesses see each other's
// effects. The receive FIFO is a one-write, one-read memory whose read data
// is prefetched into a register at the head position. A two-entry output
// buffer lets a new access enter while a response waits; req_stall rises only
// when both entries hold responses that have not been taken. No clearing pass
// is needed after reset.
module lcd_spi_panel_id_responder_top
    import lspid_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);

    // State registers.
    logic [31:0]      ctrl0_reg, ctrl0_next;
    logic [31:0]      ctrl1_reg, ctrl1_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [8:0]       head_data_reg;
    logic [8:0]       resp_word_reg [4];
    logic [2:0]       resp_len_reg, resp_len_next;
    logic [2:0]       resp_pos_reg, resp_pos_next;
    logic             busy_reg, busy_next;
    logic [8:0]       fifo_mem [FIFO_DEPTH];

    // Output buffer.
    rsp_t             out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    // Decode.
    logic             accept;
    logic             is_wr, is_data_ofs;
    logic             data_wr, data_rd, status_rd;
    logic [8:0]       frame;
    logic [7:0]       raw_byte, shift_byte, cmd;
    logic             id_raw, id_shift, id_hit;
    logic [PTR_W-1:0] head_mid;
    logic [CNT_W-1:0] count_mid;
    logic             push_ok, pop;
    logic [8:0]       push_word;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] head_inc;
    logic             queue_take;
    rsp_t             result;

    // Handshake.
    assign accept    = req_valid && !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Access decode.
    assign is_wr       = (req.req_type == REQ_WRITE);
    assign is_data_ofs = (req.reg_offset == OFS_DATA) || (req.reg_offset == OFS_DATA2);
    assign data_wr     = accept && is_wr && is_data_ofs;
    assign data_rd     = accept && !is_wr && is_data_ofs;
    assign status_rd   = accept && !is_wr && (req.reg_offset == OFS_STATUS);

    // Panel-ID command detection; the raw byte wins over the shifted byte.
    assign frame      = req.write_data[FRAME_W-1:0];
    assign raw_byte   = frame[7:0];
    assign shift_byte = frame[8:1];
    assign id_raw     = !frame[8] && is_id_byte(raw_byte);
    assign id_shift   = !frame[8] && is_id_byte(shift_byte);
    assign id_hit     = data_wr && (id_raw || id_shift);
    assign cmd        = id_raw ? raw_byte : shift_byte;

    // Pushed word: next queued word, else zero (ID command or queue spent).
    assign queue_take = data_wr && !id_hit && (resp_pos_reg < resp_len_reg);
    assign push_word  = queue_take ? resp_word_reg[resp_pos_reg[1:0]] : 9'h000;

    // FIFO pointer arithmetic.
    assign head_mid  = id_hit ? '0 : head_reg;
    assign count_mid = id_hit ? '0 : count_reg;
    assign push_ok   = data_wr && (count_mid < DEPTH_CNT);
    assign pop       = data_rd && (count_reg != '0);
    assign wr_sum    = SUM_W'(head_mid) + SUM_W'(count_mid);
    assign wr_addr   = (wr_sum >= DEPTH_SUM) ? PTR_W'(wr_sum - DEPTH_SUM) : PTR_W'(wr_sum);
    assign head_inc  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;

    // Next-state logic.
    always_comb
    begin
        ctrl0_next    = ctrl0_reg;
        ctrl1_next    = ctrl1_reg;
        head_next     = head_mid;
        count_next    = count_mid;
        resp_len_next = resp_len_reg;
        resp_pos_next = resp_pos_reg;
        busy_next     = busy_reg;
        if (accept && is_wr && (req.reg_offset == OFS_CTRL0)) begin
            ctrl0_next = req.write_data;
        end
        if (accept && is_wr && (req.reg_offset == OFS_CTRL1)) begin
            ctrl1_next = req.write_data;
        end
        if (id_hit) begin
            resp_len_next = id_resp_len(cmd);
            resp_pos_next = 3'd0;
        end else if (queue_take) begin
            resp_pos_next = resp_pos_reg + 3'd1;
        end
        if (push_ok) begin
            count_next = count_mid + 1'b1;
        end
        if (pop) begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        if (data_wr) begin
            busy_next = 1'b1;
        end
        if (status_rd) begin
            busy_next = 1'b0;
        end
    end

    // Read data and response assembly.
    always_comb
    begin
        result.read_data = 32'h0;
        if (accept && !is_wr) begin
            case (req.reg_offset)
                OFS_CTRL0:  result.read_data = ctrl0_reg;
                OFS_CTRL1:  result.read_data = ctrl1_reg;
                OFS_DATA,
                OFS_DATA2:  result.read_data = pop ? 32'(head_data_reg) : 32'h0;
                OFS_STATUS: result.read_data = STATUS_BASE
                                | ((32'(count_reg) & STATUS_CNT_MASK) << STATUS_CNT_LSB);
                default:    result.read_data = 32'h0;
            endcase
        end
        result.busy_flag = busy_next;
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl0_reg    <= '0;
            ctrl1_reg    <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            resp_len_reg <= '0;
            resp_pos_reg <= '0;
            busy_reg     <= 1'b0;
        end else begin
            ctrl0_reg    <= ctrl0_next;
            ctrl1_reg    <= ctrl1_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            resp_len_reg <= resp_len_next;
            resp_pos_reg <= resp_pos_next;
            busy_reg     <= busy_next;
        end
    end

    // Response queue words, loaded by an ID read.
    always_ff @(posedge clk)
    begin
        if (id_hit) begin
            resp_word_reg[0] <= id_resp_word(cmd, 2'd0);
            resp_word_reg[1] <= id_resp_word(cmd, 2'd1);
            resp_word_reg[2] <= id_resp_word(cmd, 2'd2);
            resp_word_reg[3] <= id_resp_word(cmd, 2'd3);
        end
    end

    // Receive FIFO memory with the head entry prefetched into a register.
    always_ff @(posedge clk)
    begin
        if (push_ok) begin
            fifo_mem[wr_addr] <= push_word;
        end
        if (push_ok && (wr_addr == head_next)) begin
            head_data_reg <= push_word;
        end else begin
            head_data_reg <= fifo_mem[head_next];
        end
    end

    // Two-entry output buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || !rsp_stall) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg  <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !rsp_stall) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    // The fill count never goes past the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("receive FIFO count exceeds depth");

    // The skid entry is only ever in use behind a held output entry.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // A transmit leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) data_wr |=> busy_reg)
        else $error("busy not set after transmit");

    // A status read clears busy.
    assert property (@(posedge clk) disable iff (!rst_n) status_rd |=> !busy_reg)
        else $error("busy not cleared by status read");

    // A pop of a non-empty FIFO lowers the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("FIFO count not decremented by pop");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Panel-ID responder testbench
// Sends register accesses to the responder and checks every response
// transaction against a cycle-free model of the registers, the receive FIFO
// and the panel-ID response queue. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lspid_pkg::*;

    localparam int FIFO_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Model state of the responder.
    logic [31:0] ctrl0_m;
    logic [31:0] ctrl1_m;
    logic [8:0]  rx_fifo_m [FIFO_DEPTH];
    int          rx_head_m;
    int          rx_count_m;
    logic [8:0]  id_words_m [4];
    int          id_len_m;
    int          id_pos_m;
    logic        busy_m;

    // Responses predicted but not yet seen, plus run statistics.
    rsp_t awaited_replies [$];
    rsp_t want;
    int   mismatches;
    int   sent;
    int   checked;
    int   id_cmds;
    int   dropped_pushes;
    int   status_reads;
    int   max_fill;
    logic idle_on = 1'b1;
    logic rsp_taken = 1'b0;
    int   rsp_wait = 0;

    lcd_spi_panel_id_responder_top #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // True for a byte that selects a panel-ID read.
    function automatic logic names_id_cmd(input logic [7:0] b);
        return (b == CMD_READ_ID) || ((b >= CMD_ID1) && (b <= CMD_ID_LAST));
    endfunction

    // Applies one access to the model state and returns the expected response.
    function automatic rsp_t access_reply(input req_t a);
        rsp_t       r;
        logic [8:0] frame;
        logic [8:0] word;
        logic [7:0] cmd;
        logic       hit;
        r     = '0;
        word  = '0;
        cmd   = '0;
        hit   = 1'b0;
        frame = a.write_data[8:0];
        if (a.req_type == REQ_WRITE) begin
            case (a.reg_offset)
                OFS_CTRL0: ctrl0_m = a.write_data;
                OFS_CTRL1: ctrl1_m = a.write_data;
                OFS_DATA, OFS_DATA2:
                begin
                    // Command frames may carry the ID byte raw or one bit up.
                    if (!frame[8]) begin
                        if (names_id_cmd(frame[7:0])) begin
                            hit = 1'b1;
                            cmd = frame[7:0];
                        end else if (names_id_cmd(frame[8:1])) begin
                            hit = 1'b1;
                            cmd = frame[8:1];
                        end
                    end
                    if (hit) begin
                        id_cmds++;
                        rx_head_m  = 0;
                        rx_count_m = 0;
                        id_len_m   = 0;
                        id_pos_m   = 0;
                        if (cmd == CMD_READ_ID) begin
                            id_words_m[0] = RID_WORD0;
                            id_words_m[1] = RID_WORD1;
                            id_words_m[2] = RID_WORD2;
                            id_words_m[3] = RID_WORD3;
                            id_len_m = 4;
                        end else if (cmd == CMD_ID1) begin
                            id_words_m[0] = {ID1_BYTE, 1'b0};
                            id_len_m = 1;
                        end else if (cmd == CMD_ID2) begin
                            id_words_m[0] = {ID2_BYTE, 1'b0};
                            id_len_m = 1;
                        end else if (cmd == CMD_ID3) begin
                            id_words_m[0] = {ID3_BYTE, 1'b0};
                            id_len_m = 1;
                        end
                    end else if (id_pos_m < id_len_m) begin
                        word = id_words_m[id_pos_m];
                        id_pos_m++;
                    end
                    // Every frame pushes one word unless the FIFO is full.
                    if (rx_count_m < FIFO_DEPTH) begin
                        rx_fifo_m[(rx_head_m + rx_count_m) % FIFO_DEPTH] = word;
                        rx_count_m++;
                        if (rx_count_m > max_fill) begin
                            max_fill = rx_count_m;
                        end
                    end else begin
                        dropped_pushes++;
                    end
                    busy_m = 1'b1;
                end
                default: ;
            endcase
        end else begin
            case (a.reg_offset)
                OFS_CTRL0: r.read_data = ctrl0_m;
                OFS_CTRL1: r.read_data = ctrl1_m;
                OFS_DATA, OFS_DATA2:
                begin
                    if (rx_count_m > 0) begin
                        r.read_data = {23'd0, rx_fifo_m[rx_head_m]};
                        rx_head_m   = (rx_head_m + 1) % FIFO_DEPTH;
                        rx_count_m--;
                    end
                end
                OFS_STATUS:
                begin
                    r.read_data = STATUS_BASE |
                                  ((32'(rx_count_m) & STATUS_CNT_MASK) << STATUS_CNT_LSB);
                    busy_m = 1'b0;
                    status_reads++;
                end
                default: ;
            endcase
        end
        r.busy_flag = busy_m;
        return r;
    endfunction

    // Sends one access after a random gap and waits until it is accepted.
    task automatic send_access(input logic kind, input logic [11:0] ofs,
                               input logic [31:0] data);
        int gap;
        req_t item;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        item.req_type   = kind;
        item.reg_offset = ofs;
        item.write_data = data;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do begin
            @(posedge clk);
        end while (req_stall);
        sent++;
    endtask

    // Predict at request acceptance and check each accepted response.
    always @(posedge clk) begin
        if (rst_n) begin
            rsp_taken <= rsp_valid && !rsp_stall;
            if (rsp_valid && !rsp_stall) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected response read_data=%h busy=%b",
                             $time, rsp.read_data, rsp.busy_flag);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    checked++;
                    if (rsp.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                        mismatches++;
                    end
                    if (rsp.busy_flag !== want.busy_flag) begin
                        $display("%0t: busy_flag expected %b actual %b",
                                 $time, want.busy_flag, rsp.busy_flag);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall) begin
                awaited_replies.push_back(access_reply(req));
            end
        end
    end

    // After each taken response the receiver stalls for a random count.
    always @(negedge clk) begin
        if (rsp_taken) begin
            rsp_wait = idle_on ? $urandom_range(0, 3) : 0;
        end
        if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Control words, unmapped offsets and writes to status.
    task automatic test_control_regs();
        send_access(REQ_WRITE, OFS_CTRL0, 32'hFFFF_FFFF);
        send_access(REQ_WRITE, OFS_CTRL1, 32'h5A5A_A5A5);
        send_access(REQ_READ, OFS_CTRL0, $urandom());
        send_access(REQ_READ, OFS_CTRL1, $urandom());
        send_access(REQ_WRITE, 12'hFFF, 32'hFFFF_FFFF);
        send_access(REQ_READ, 12'hFFF, 32'h0);
        send_access(REQ_WRITE, OFS_STATUS, 32'hFFFF_FFFF);
        send_access(REQ_READ, OFS_STATUS, 32'h0);
    endtask

    // Full ID read, ID2 and the last ID code, queue exhaustion and an empty pop.
    task automatic test_panel_id_commands();
        send_access(REQ_READ, OFS_DATA, 32'h0);
        send_access(REQ_WRITE, OFS_DATA, 32'h8000_0004);
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_01FF);
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_0100);
        // A command frame that is not an ID read still takes a queued word.
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_00AA);
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_0155);
        send_access(REQ_WRITE, OFS_DATA, 32'hFFFF_FFFF);
        send_access(REQ_READ, OFS_STATUS, 32'h0);
        send_access(REQ_READ, OFS_DATA, 32'h0);
        send_access(REQ_READ, OFS_DATA2, 32'h0);
        send_access(REQ_WRITE, OFS_DATA2, 32'hFFFF_FEDB);
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_0100);
        // Command byte found one bit up in the frame.
        send_access(REQ_WRITE, OFS_DATA, 32'h0000_0009);
        send_access(REQ_WRITE, OFS_DATA, {24'd0, CMD_ID_LAST});
        send_access(REQ_READ, OFS_DATA2, 32'h0);
    endtask

    // One frame write with random upper bits; data frames mostly.
    task automatic send_frame_write(input logic data_frame);
        logic [31:0] d;
        d = $urandom();
        if (data_frame) begin
            d[8] = 1'b1;
        end
        send_access(REQ_WRITE, $urandom_range(0, 1) ? OFS_DATA : OFS_DATA2, d);
    endtask

    // ID command sequences with random content, mixed with random noise.
    task automatic test_random_traffic();
        int          goal;
        int          frames;
        int          drains;
        int          p;
        logic        fill_only;
        logic [8:0]  frame;
        logic [31:0] d;
        logic [11:0] ofs;
        goal = sent + RANDOM_ITEMS;
        while (sent < goal) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6) begin
                // Pick an ID command, raw or one bit up.
                case ($urandom_range(0, 7))
                    0: frame = {1'b0, CMD_READ_ID};
                    1: frame = {1'b0, CMD_ID1};
                    2: frame = {1'b0, CMD_ID2};
                    3: frame = {1'b0, CMD_ID3};
                    4: frame = {1'b0, CMD_ID3 + 8'd1};
                    5: frame = {1'b0, CMD_ID_LAST - 8'd1};
                    6: frame = {1'b0, CMD_ID_LAST};
                    default: frame = {CMD_READ_ID, 1'($urandom_range(0, 1))};
                endcase
                d = $urandom();
                d[8:0] = frame;
                send_access(REQ_WRITE, $urandom_range(0, 1) ? OFS_DATA : OFS_DATA2, d);
                frames    = $urandom_range(0, 20);
                fill_only = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < frames; i++) begin
                    p = fill_only ? 0 : $urandom_range(0, 9);
                    if (p < 5) begin
                        send_frame_write(1'b1);
                    end else if (p == 5) begin
                        send_frame_write(1'b0);
                    end else if (p < 8) begin
                        send_access(REQ_READ, $urandom_range(0, 1) ? OFS_DATA : OFS_DATA2,
                                    $urandom());
                    end else if (p == 8) begin
                        send_access(REQ_READ, OFS_STATUS, $urandom());
                    end else begin
                        send_access(1'($urandom_range(0, 1)),
                                    $urandom_range(0, 1) ? OFS_CTRL0 : OFS_CTRL1, $urandom());
                    end
                end
                drains = $urandom_range(0, 18);
                for (int i = 0; i < drains; i++) begin
                    send_access(REQ_READ, $urandom_range(0, 1) ? OFS_DATA : OFS_DATA2,
                                $urandom());
                end
                send_access(REQ_READ, OFS_STATUS, $urandom());
            end else begin
                // Noise: any access, often at an arbitrary offset.
                case ($urandom_range(0, 5))
                    0: ofs = OFS_CTRL0;
                    1: ofs = OFS_CTRL1;
                    2: ofs = OFS_DATA;
                    3: ofs = OFS_STATUS;
                    4: ofs = OFS_DATA2;
                    default: ofs = 12'($urandom_range(0, 4095));
                endcase
                send_access(1'($urandom_range(0, 1)), ofs, $urandom());
            end
        end
    endtask

    // Main sequence.
    initial begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        mismatches     = 0;
        sent           = 0;
        checked        = 0;
        id_cmds        = 0;
        dropped_pushes = 0;
        status_reads   = 0;
        max_fill       = 0;
        ctrl0_m        = '0;
        ctrl1_m        = '0;
        rx_head_m      = 0;
        rx_count_m     = 0;
        id_len_m       = 0;
        id_pos_m       = 0;
        busy_m         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_control_regs();
        test_panel_id_commands();
        test_random_traffic();

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_replies.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d responses to %0d accesses, %0d panel-ID commands.",
                 checked, sent, id_cmds);
        $display("FIFO filled up to %0d entries, %0d pushes dropped, %0d status reads.",
                 max_fill, dropped_pushes, status_reads);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* lcd_spi_panel_id_responder_top.f */
hw/rtl/lspid_pkg.sv
hw/rtl/lcd_spi_panel_id_responder_top.sv
test/tb_top.sv
